### design/rtmx_pkg.sv
`default_nettype none
package rtmx_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int MAX_STAGES    = 32;
  localparam int NUM_STAGES    = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;
  localparam int STAGE_W       = $clog2(MAX_STAGES);
  localparam int CW            = 34;
  localparam int SCW           = 32;
  localparam int AW            = 16;
  localparam int MW            = 16;

  localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 flip;
  } cord_t;

  function automatic logic signed [CW-1:0] atan_at(logic [STAGE_W-1:0] i);
    logic signed [CW-1:0] r;
    unique case (i)
      5'd0:  r = 34'sd843314857;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043837;
      5'd3:  r = 34'sd133525159;
      5'd4:  r = 34'sd67021688;
      5'd5:  r = 34'sd33543516;
      5'd6:  r = 34'sd16775851;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194283;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048576;
      5'd11: r = 34'sd524288;
      5'd12: r = 34'sd262144;
      5'd13: r = 34'sd131072;
      5'd14: r = 34'sd65536;
      5'd15: r = 34'sd32768;
      5'd16: r = 34'sd16384;
      5'd17: r = 34'sd8192;
      5'd18: r = 34'sd4096;
      5'd19: r = 34'sd2048;
      5'd20: r = 34'sd1024;
      5'd21: r = 34'sd512;
      5'd22: r = 34'sd256;
      5'd23: r = 34'sd128;
      5'd24: r = 34'sd64;
      5'd25: r = 34'sd32;
      5'd26: r = 34'sd16;
      5'd27: r = 34'sd8;
      5'd28: r = 34'sd4;
      5'd29: r = 34'sd2;
      5'd30: r = 34'sd1;
      5'd31: r = 34'sd0;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### design/rtmx_cordic_cell.sv
`default_nettype none
module rtmx_cordic_cell (
  input  wire                             clk_i,
  input  wire                             en_i,
  input  wire [rtmx_pkg::STAGE_W-1:0]     stage_i,
  input  rtmx_pkg::cord_t                 cord_i,
  output rtmx_pkg::cord_t                 cord_o
);
  import rtmx_pkg::*;

  logic signed [CW-1:0] dx, dy, at;
  cord_t cord_d, cord_q;

  always_comb begin
    dx = cord_i.y >>> stage_i;
    dy = cord_i.x >>> stage_i;
    at = atan_at(stage_i);
    cord_d.flip = cord_i.flip;
    if (!cord_i.z[CW-1]) begin
      cord_d.x = cord_i.x - dx;
      cord_d.y = cord_i.y + dy;
      cord_d.z = cord_i.z - at;
    end else begin
      cord_d.x = cord_i.x + dx;
      cord_d.y = cord_i.y - dy;
      cord_d.z = cord_i.z + at;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cord_q <= cord_d;
    end
  end

  assign cord_o = cord_q;

endmodule
`default_nettype wire

### design/rtmx_matrix.sv
`default_nettype none
module rtmx_matrix (
  input  wire                                 clk_i,
  input  wire                                 en_i,
  input  rtmx_pkg::cord_t                     roll_i,
  input  rtmx_pkg::cord_t                     pitch_i,
  input  rtmx_pkg::cord_t                     yaw_i,
  output logic signed [rtmx_pkg::MW-1:0]      m00_o,
  output logic signed [rtmx_pkg::MW-1:0]      m01_o,
  output logic signed [rtmx_pkg::MW-1:0]      m02_o,
  output logic signed [rtmx_pkg::MW-1:0]      m10_o,
  output logic signed [rtmx_pkg::MW-1:0]      m11_o,
  output logic signed [rtmx_pkg::MW-1:0]      m12_o,
  output logic signed [rtmx_pkg::MW-1:0]      m20_o,
  output logic signed [rtmx_pkg::MW-1:0]      m21_o,
  output logic signed [rtmx_pkg::MW-1:0]      m22_o
);
  import rtmx_pkg::*;

  function automatic logic signed [SCW-1:0] fin_cos(cord_t c);
    logic signed [CW-1:0] v;
    v = c.flip ? -c.x : c.x;
    return v[SCW-1:0];
  endfunction

  function automatic logic signed [SCW-1:0] fin_sin(cord_t c);
    logic signed [CW-1:0] v;
    v = c.flip ? -c.y : c.y;
    return v[SCW-1:0];
  endfunction

  function automatic logic signed [47:0] mul16(logic signed [SCW-1:0] a,
                                               logic signed [SCW-1:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[63:16];
  endfunction

  function automatic logic signed [SCW-1:0] mul30(logic signed [SCW-1:0] a,
                                                  logic signed [SCW-1:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[61:30];
  endfunction

  function automatic logic signed [49:0] sx(logic signed [47:0] a);
    return {{2{a[47]}}, a};
  endfunction

  function automatic logic signed [MW-1:0] to_out(logic signed [49:0] v);
    logic signed [49:0] s;
    logic signed [19:0] r;
    logic signed [MW-1:0] o;
    s = v + 50'sd536870912;
    r = s[49:30];
    if (r > 20'sd16384) begin
      o = 16'sd16384;
    end else if (r < -20'sd16384) begin
      o = -16'sd16384;
    end else begin
      o = r[MW-1:0];
    end
    return o;
  endfunction

  logic signed [SCW-1:0] sr, cr, sp, cp, sy, cy;

  logic signed [47:0]    cycp_q, sycr_q, sysr_q, sycp_q, cycr_q, cysr_q, cpsr_q, cpcr_q;
  logic signed [SCW-1:0] spsr_q, spcr_q, cy1_q, sy1_q, sp1_q;

  logic signed [47:0]    a_q, b_q, c_q, d_q;
  logic signed [47:0]    cycp2_q, sycr2_q, sysr2_q, sycp2_q, cycr2_q, cysr2_q;
  logic signed [47:0]    cpsr2_q, cpcr2_q;
  logic signed [SCW-1:0] sp2_q;
  logic signed [49:0]    nsp;

  assign sr = fin_sin(roll_i);
  assign cr = fin_cos(roll_i);
  assign sp = fin_sin(pitch_i);
  assign cp = fin_cos(pitch_i);
  assign sy = fin_sin(yaw_i);
  assign cy = fin_cos(yaw_i);

  assign nsp = -({{18{sp2_q[SCW-1]}}, sp2_q} <<< 14);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cycp_q <= mul16(cy, cp);
      sycr_q <= mul16(sy, cr);
      sysr_q <= mul16(sy, sr);
      sycp_q <= mul16(sy, cp);
      cycr_q <= mul16(cy, cr);
      cysr_q <= mul16(cy, sr);
      cpsr_q <= mul16(cp, sr);
      cpcr_q <= mul16(cp, cr);
      spsr_q <= mul30(sp, sr);
      spcr_q <= mul30(sp, cr);
      cy1_q  <= cy;
      sy1_q  <= sy;
      sp1_q  <= sp;

      a_q     <= mul16(spsr_q, cy1_q);
      b_q     <= mul16(spcr_q, cy1_q);
      c_q     <= mul16(spsr_q, sy1_q);
      d_q     <= mul16(spcr_q, sy1_q);
      cycp2_q <= cycp_q;
      sycr2_q <= sycr_q;
      sysr2_q <= sysr_q;
      sycp2_q <= sycp_q;
      cycr2_q <= cycr_q;
      cysr2_q <= cysr_q;
      cpsr2_q <= cpsr_q;
      cpcr2_q <= cpcr_q;
      sp2_q   <= sp1_q;

      m00_o <= to_out(sx(cycp2_q));
      m01_o <= to_out(sx(a_q) - sx(sycr2_q));
      m02_o <= to_out(sx(b_q) + sx(sysr2_q));
      m10_o <= to_out(sx(sycp2_q));
      m11_o <= to_out(sx(c_q) + sx(cycr2_q));
      m12_o <= to_out(sx(d_q) - sx(cysr2_q));
      m20_o <= to_out(nsp);
      m21_o <= to_out(sx(cpsr2_q));
      m22_o <= to_out(sx(cpcr2_q));
    end
  end

endmodule
`default_nettype wire

### design/rpy_to_rotation_matrix.sv
`default_nettype none
// Channel  | Handshake              | Payload
// in       | in_valid_i, in_stall_o | roll_angle_i, pitch_angle_i, yaw_angle_i
// out      | out_valid_o, out_stall_i | m00_o .. m22_o
//
// One item per cycle while no result is stalled. Stages: angle reduction,
// one CORDIC cell per iteration, two multiply stages, sum/round/saturate.
// Reset clears only the valid bits of the pipeline.
// A stalled result freezes the whole pipeline; in_stall_o follows it.
module rpy_to_rotation_matrix (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire signed [rtmx_pkg::AW-1:0]       roll_angle_i,
  input  wire signed [rtmx_pkg::AW-1:0]       pitch_angle_i,
  input  wire signed [rtmx_pkg::AW-1:0]       yaw_angle_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic signed [rtmx_pkg::MW-1:0]      m00_o,
  output logic signed [rtmx_pkg::MW-1:0]      m01_o,
  output logic signed [rtmx_pkg::MW-1:0]      m02_o,
  output logic signed [rtmx_pkg::MW-1:0]      m10_o,
  output logic signed [rtmx_pkg::MW-1:0]      m11_o,
  output logic signed [rtmx_pkg::MW-1:0]      m12_o,
  output logic signed [rtmx_pkg::MW-1:0]      m20_o,
  output logic signed [rtmx_pkg::MW-1:0]      m21_o,
  output logic signed [rtmx_pkg::MW-1:0]      m22_o
);
  import rtmx_pkg::*;

  localparam int DEPTH = NUM_STAGES + 4;

  function automatic cord_t reduce(logic signed [AW-1:0] a);
    cord_t c;
    logic signed [CW-1:0] z;
    z = {a[AW-1], a, 17'b0};
    c.x = GAIN_Q30;
    c.y = '0;
    c.flip = 1'b0;
    if (z > HALF_PI_Q30) begin
      z = z - PI_Q30;
      c.flip = 1'b1;
    end else if (z < -HALF_PI_Q30) begin
      z = z + PI_Q30;
      c.flip = 1'b1;
    end
    c.z = z;
    return c;
  endfunction

  logic              en;
  logic [DEPTH-1:0]  vld_q;
  cord_t             chain [3][NUM_STAGES+1];

  assign en          = !(vld_q[DEPTH-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DEPTH-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      chain[0][0] <= reduce(roll_angle_i);
      chain[1][0] <= reduce(pitch_angle_i);
      chain[2][0] <= reduce(yaw_angle_i);
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_ang
    for (genvar i = 0; i < NUM_STAGES; i++) begin : g_cell
      rtmx_cordic_cell u_cell (
        .clk_i   (clk_i),
        .en_i    (en),
        .stage_i (STAGE_W'(i)),
        .cord_i  (chain[k][i]),
        .cord_o  (chain[k][i+1])
      );
    end
  end

  rtmx_matrix u_matrix (
    .clk_i   (clk_i),
    .en_i    (en),
    .roll_i  (chain[0][NUM_STAGES]),
    .pitch_i (chain[1][NUM_STAGES]),
    .yaw_i   (chain[2][NUM_STAGES]),
    .m00_o   (m00_o),
    .m01_o   (m01_o),
    .m02_o   (m02_o),
    .m10_o   (m10_o),
    .m11_o   (m11_o),
    .m12_o   (m12_o),
    .m20_o   (m20_o),
    .m21_o   (m21_o),
    .m22_o   (m22_o)
  );

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(m11_o)))
    else $error("held item lost");

  a_m20_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (m20_o <= 16'sd16384 && m20_o >= -16'sd16384))
    else $error("m20 out of range");

  a_m01_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (m01_o <= 16'sd16384 && m01_o >= -16'sd16384))
    else $error("m01 out of range");

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && !in_valid_i) |=> !vld_q[0])
    else $error("bubble not tracked");

endmodule
`default_nettype wire

### tb/tb.sv
module tb;
  import rtmx_pkg::*;

  localparam int LATENCY   = CORDIC_STAGES + 4;
  localparam int NUM_RAND  = 400;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic signed [AW-1:0] roll;
    logic signed [AW-1:0] pitch;
    logic signed [AW-1:0] yaw;
  } angles_t;

  typedef struct packed {
    logic signed [MW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } matrix_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic in_stall_o, out_valid_o;
  logic signed [AW-1:0] roll_angle_i = '0, pitch_angle_i = '0, yaw_angle_i = '0;
  logic signed [MW-1:0] m00_o, m01_o, m02_o, m10_o, m11_o, m12_o, m20_o, m21_o, m22_o;

  rpy_to_rotation_matrix i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .roll_angle_i, .pitch_angle_i, .yaw_angle_i,
    .out_valid_o, .out_stall_i,
    .m00_o, .m01_o, .m02_o, .m10_o, .m11_o, .m12_o, .m20_o, .m21_o, .m22_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  angles_t pending_angles[$];
  matrix_t expected_matrices[$];
  int unsigned mismatches = 0;
  int unsigned sent = 0, received = 0;
  int unsigned idle_cycles = 0;
  bit calm = 1'b0;
  bit hold_sender = 1'b0;
  bit in_taken = 1'b0;

  function automatic longint atan_q30(int i);
    longint tab[32] = '{843314857, 497837829, 263043837, 133525159, 67021688, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536,
      32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0};
    return tab[i];
  endfunction

  function automatic void cordic_sin_cos(input logic signed [AW-1:0] ang,
                                         output longint sn, output longint cs);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(ang) * (longint'(1) << 17);
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (z > 1686629713) begin
      z -= 64'sd3373259426;
      flip = 1'b1;
    end else if (z < -1686629713) begin
      z += 64'sd3373259426;
      flip = 1'b1;
    end
    for (int i = 0; i < NUM_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q30(i);
      end else begin
        x += dx; y -= dy; z += atan_q30(i);
      end
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic longint mul2(longint a, longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic longint mul3(longint a, longint b, longint c);
    return (((a * b) >>> 30) * c) >>> 16;
  endfunction

  function automatic logic signed [MW-1:0] round_sat(longint v);
    longint r;
    r = (v + (longint'(1) << 29)) >>> 30;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[MW-1:0];
  endfunction

  function automatic matrix_t rotation_of(angles_t a);
    longint sr, cr, sp, cp, sy, cy;
    matrix_t m;
    cordic_sin_cos(a.roll, sr, cr);
    cordic_sin_cos(a.pitch, sp, cp);
    cordic_sin_cos(a.yaw, sy, cy);
    m.m00 = round_sat(mul2(cy, cp));
    m.m01 = round_sat(mul3(sp, sr, cy) - mul2(sy, cr));
    m.m02 = round_sat(mul3(sp, cr, cy) + mul2(sy, sr));
    m.m10 = round_sat(mul2(sy, cp));
    m.m11 = round_sat(mul3(sp, sr, sy) + mul2(cy, cr));
    m.m12 = round_sat(mul3(sp, cr, sy) - mul2(cy, sr));
    m.m20 = round_sat(-sp * 16384);
    m.m21 = round_sat(mul2(cp, sr));
    m.m22 = round_sat(mul2(cp, cr));
    return m;
  endfunction

  function automatic logic signed [AW-1:0] pick_angle();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return (AW'($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000);
    if (sel == 1) return AW'($urandom_range(12768, 13000));
    if (sel == 2) return -AW'($urandom_range(12768, 13000));
    return AW'($urandom);
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (pending_angles.size() > 0 && !hold_sender &&
            (calm || $urandom_range(0, 99) >= 32)) begin
          in_valid_i <= 1'b1;
          roll_angle_i <= pending_angles[0].roll;
          pitch_angle_i <= pending_angles[0].pitch;
          yaw_angle_i <= pending_angles[0].yaw;
          pending_angles.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= calm ? 1'b0 : ($urandom_range(0, 99) < 32);
    end
  end

  always @(posedge clk_i) begin
    matrix_t got, want;
    if (rst_ni) begin
      idle_cycles++;
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        expected_matrices.push_back(rotation_of({roll_angle_i, pitch_angle_i, yaw_angle_i}));
        sent <= sent + 1;
        idle_cycles = 0;
      end
      if (out_valid_o && !out_stall_i) begin
        idle_cycles = 0;
        received <= received + 1;
        got = {m00_o, m01_o, m02_o, m10_o, m11_o, m12_o, m20_o, m21_o, m22_o};
        if (expected_matrices.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected matrix %h", got);
        end else begin
          want = expected_matrices.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("matrix mismatch: expected %h got %h", want, got);
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin
    angles_t a;
    logic signed [AW-1:0] edges[6] = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0001,
                                       16'sh3244, -16'sh3244};
    foreach (edges[i]) pending_angles.push_back({edges[i], edges[(i + 1) % 6], edges[(i + 2) % 6]});
    pending_angles.push_back({16'sh6488, 16'sh6488, 16'sh6488});
    pending_angles.push_back({-16'sh6488, 16'sh3243, -16'sh3243});
    pending_angles.push_back({16'sh3245, -16'sh3245, 16'sh1922});
    pending_angles.push_back({16'shffff, 16'sh5555, 16'shaaaa});
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    for (int n = 0; n < NUM_RAND; n++) begin
      a.roll = pick_angle();
      a.pitch = pick_angle();
      a.yaw = pick_angle();
      pending_angles.push_back(a);
      if (n == 150) begin
        wait (pending_angles.size() == 0);
        hold_sender = 1'b1;
        @(negedge clk_i);
        wait (!in_valid_i);
        wait (expected_matrices.size() == 0);
        @(negedge clk_i) hold_sender = 1'b0;
        calm = 1'b1;
      end
      if (n == 250) begin
        wait (pending_angles.size() == 0);
        calm = 1'b0;
      end
    end
    wait (pending_angles.size() == 0);
    @(negedge clk_i);
    wait (!in_valid_i);
    wait (expected_matrices.size() == 0);
    repeat (LATENCY + 5) @(posedge clk_i);
    $display("sent %0d angle triples, %0d matrices checked, %0d mismatches",
             sent, received, mismatches);
    $display("covered angle extremes, wrap beyond +-pi/2, random stalls and a drain pause");
    if (mismatches == 0 && expected_matrices.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule

### files.f
design/rtmx_pkg.sv
design/rtmx_cordic_cell.sv
design/rtmx_matrix.sv
design/rpy_to_rotation_matrix.sv
tb/tb.sv
